// ----- rtl/va_pkg.sv -----
`timescale 1ns / 1ps

package va_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int COORD_BITS_DEF    = 16;

  localparam int TAB_LEN  = 24;
  localparam int NORM_TOP = 30;
  localparam int NORM_W   = NORM_TOP + 1;
  localparam int XY_W     = 34;
  localparam int Z_W      = 24;
  localparam int TH_W     = 23;
  localparam int ANGLE_W  = 17;

  localparam int DEG90_UNITS  = 2949120;
  localparam int DEG180_UNITS = 5898240;
  localparam int OUT_360      = 46080;
  localparam int OUT_180      = 23040;
  localparam int ROUND_HALF   = 128;

  typedef enum logic {
    REQ_CCW    = 1'b0,
    REQ_SIGNED = 1'b1
  } req_t;

  typedef struct packed {
    logic valid;
    req_t kind;
    logic zero;
    logic cneg;
    logic dneg;
    logic czero;
    logic dzero;
  } va_flags_t;

  // atan(2^-i) in units of 2^-15 degree
  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      0:       v = Z_W'(1474560);
      1:       v = Z_W'(870484);
      2:       v = Z_W'(459940);
      3:       v = Z_W'(233473);
      4:       v = Z_W'(117189);
      5:       v = Z_W'(58652);
      6:       v = Z_W'(29333);
      7:       v = Z_W'(14667);
      8:       v = Z_W'(7334);
      9:       v = Z_W'(3667);
      10:      v = Z_W'(1833);
      11:      v = Z_W'(917);
      12:      v = Z_W'(458);
      13:      v = Z_W'(229);
      14:      v = Z_W'(115);
      15:      v = Z_W'(57);
      16:      v = Z_W'(29);
      17:      v = Z_W'(14);
      18:      v = Z_W'(7);
      19:      v = Z_W'(4);
      20:      v = Z_W'(2);
      21:      v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/va_front.sv -----
`timescale 1ns / 1ps

module va_front #(
  parameter int COORD_BITS = va_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic                         req_type,
  input  logic signed [COORD_BITS-1:0] ref_x,
  input  logic signed [COORD_BITS-1:0] ref_y,
  input  logic signed [COORD_BITS-1:0] vec_x,
  input  logic signed [COORD_BITS-1:0] vec_y,
  output va_pkg::va_flags_t            flags,
  output logic [2*COORD_BITS-1:0]      cmag,
  output logic [2*COORD_BITS-1:0]      dmag
);

  localparam int PW = 2 * COORD_BITS;
  localparam int SW = PW + 1;

  va_pkg::va_flags_t       f1;
  logic signed [PW-1:0]    ax_by, ay_bx, ax_bx, ay_by;
  logic signed [SW-1:0]    c_sum, d_sum;
  logic                    zero_in;

  assign zero_in = ((ref_x == '0) && (ref_y == '0)) || ((vec_x == '0) && (vec_y == '0));

  // products
  always_ff @(posedge clk) begin
    if (rst) begin
      f1 <= '0;
    end else if (en) begin
      f1 <= '{valid: in_valid, kind: va_pkg::req_t'(req_type), zero: zero_in,
              cneg: 1'b0, dneg: 1'b0, czero: 1'b0, dzero: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_by <= PW'(ref_x) * PW'(vec_y);
      ay_bx <= PW'(ref_y) * PW'(vec_x);
      ax_bx <= PW'(ref_x) * PW'(vec_x);
      ay_by <= PW'(ref_y) * PW'(vec_y);
    end
  end

  // cross and dot, sign and magnitude
  assign c_sum = SW'(ax_by) - SW'(ay_bx);
  assign d_sum = SW'(ax_bx) + SW'(ay_by);

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (en) begin
      flags <= '{valid: f1.valid, kind: f1.kind, zero: f1.zero,
                 cneg: c_sum[SW-1], dneg: d_sum[SW-1], czero: 1'b0, dzero: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmag <= c_sum[SW-1] ? PW'(-c_sum) : PW'(c_sum);
      dmag <= d_sum[SW-1] ? PW'(-d_sum) : PW'(d_sum);
    end
  end

endmodule

// ----- rtl/va_norm.sv -----
`timescale 1ns / 1ps

module va_norm #(
  parameter int COORD_BITS = va_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  va_pkg::va_flags_t             flags_in,
  input  logic [2*COORD_BITS-1:0]       cmag,
  input  logic [2*COORD_BITS-1:0]       dmag,
  output va_pkg::va_flags_t             flags,
  output logic [va_pkg::NORM_W-1:0]     x_norm,
  output logic [va_pkg::NORM_W-1:0]     y_norm
);

  localparam int MW = 2 * COORD_BITS;
  localparam int NW = ((MW + 7) / 8) * 8;
  localparam int NG = NW / 8;
  localparam int GW = $clog2(NG);
  localparam int EW = NW + va_pkg::NORM_W;

  va_pkg::va_flags_t  fa;
  logic [NW-1:0]      c_w, d_w, or_w;
  logic [GW-1:0]      lzg;
  logic               found_g;
  logic [NW-1:0]      c_a, d_a, or_a;
  logic [7:0]         top_a;
  logic [2:0]         lzb;
  logic               found_b;
  logic [NW-1:0]      c_b, d_b;
  logic [EW-1:0]      c_ext, d_ext;

  assign c_w  = NW'(cmag);
  assign d_w  = NW'(dmag);
  assign or_w = c_w | d_w;

  // coarse step: whole leading zero bytes
  always_comb begin
    lzg     = '0;
    found_g = 1'b0;
    for (int g = NG - 1; g >= 1; g--) begin
      if (!found_g) begin
        if (or_w[g*8 +: 8] != 8'd0) begin
          found_g = 1'b1;
        end else begin
          lzg = lzg + GW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fa <= '0;
    end else if (en) begin
      fa <= '{valid: flags_in.valid, kind: flags_in.kind, zero: flags_in.zero,
              cneg: flags_in.cneg, dneg: flags_in.dneg,
              czero: (cmag == '0), dzero: (dmag == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_a <= c_w << {lzg, 3'b000};
      d_a <= d_w << {lzg, 3'b000};
    end
  end

  // fine step: leading zeros inside the top byte
  assign or_a  = c_a | d_a;
  assign top_a = or_a[NW-1 -: 8];

  always_comb begin
    lzb     = '0;
    found_b = 1'b0;
    for (int b = 7; b >= 1; b--) begin
      if (!found_b) begin
        if (top_a[b]) begin
          found_b = 1'b1;
        end else begin
          lzb = lzb + 3'd1;
        end
      end
    end
  end

  assign c_b   = c_a << lzb;
  assign d_b   = d_a << lzb;
  assign c_ext = {c_b, {va_pkg::NORM_W{1'b0}}};
  assign d_ext = {d_b, {va_pkg::NORM_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (en) begin
      flags <= fa;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_norm <= d_ext[EW-1 -: va_pkg::NORM_W];
      y_norm <= c_ext[EW-1 -: va_pkg::NORM_W];
    end
  end

endmodule

// ----- rtl/va_cordic.sv -----
`timescale 1ns / 1ps

module va_cordic #(
  parameter int CORDIC_STAGES = va_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  va_pkg::va_flags_t                flags_in,
  input  logic [va_pkg::NORM_W-1:0]        x_in,
  input  logic [va_pkg::NORM_W-1:0]        y_in,
  output va_pkg::va_flags_t                flags,
  output logic signed [va_pkg::Z_W-1:0]    z
);

  localparam int XY_W = va_pkg::XY_W;
  localparam int Z_W  = va_pkg::Z_W;

  va_pkg::va_flags_t       fs [0:CORDIC_STAGES];
  logic signed [XY_W-1:0]  xs [0:CORDIC_STAGES];
  logic signed [XY_W-1:0]  ys [0:CORDIC_STAGES];
  logic signed [Z_W-1:0]   zs [0:CORDIC_STAGES];

  assign fs[0] = flags_in;
  assign xs[0] = XY_W'(x_in);
  assign ys[0] = XY_W'(y_in);
  assign zs[0] = '0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        fs[i+1] <= '0;
      end else if (en) begin
        fs[i+1] <= fs[i];
      end
    end

    // rotate toward y = 0
    always_ff @(posedge clk) begin
      if (en) begin
        if (!ys[i][XY_W-1]) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + va_pkg::atan_entry(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - va_pkg::atan_entry(i);
        end
      end
    end
  end

  assign flags = fs[CORDIC_STAGES];
  assign z     = zs[CORDIC_STAGES];

endmodule

// ----- rtl/va_post.sv -----
`timescale 1ns / 1ps

module va_post (
  input  logic                                clk,
  input  logic                                rst,
  input  va_pkg::va_flags_t                   flags_in,
  input  logic signed [va_pkg::Z_W-1:0]       z,
  input  logic                                out_stall,
  output logic                                en,
  output logic                                out_valid,
  output logic signed [va_pkg::ANGLE_W-1:0]   angle,
  output logic                                zero_vector
);

  localparam int Z_W     = va_pkg::Z_W;
  localparam int TH_W    = va_pkg::TH_W;
  localparam int ANGLE_W = va_pkg::ANGLE_W;
  localparam int R_W     = TH_W - 7;
  localparam logic signed [Z_W-1:0]     Z90      = Z_W'(va_pkg::DEG90_UNITS);
  localparam logic [TH_W-1:0]           TH90     = TH_W'(va_pkg::DEG90_UNITS);
  localparam logic [TH_W-1:0]           TH180    = TH_W'(va_pkg::DEG180_UNITS);
  localparam logic signed [ANGLE_W-1:0] A360     = ANGLE_W'(va_pkg::OUT_360);
  localparam logic signed [ANGLE_W-1:0] A180     = ANGLE_W'(va_pkg::OUT_180);
  localparam logic signed [ANGLE_W-1:0] A180_NEG = -ANGLE_W'(va_pkg::OUT_180);

  va_pkg::va_flags_t            fp;
  logic [TH_W-1:0]              zc, phi, theta_next, theta;
  logic [TH_W:0]                rsum;
  logic [R_W-1:0]               r;
  logic signed [ANGLE_W-1:0]    rs, res;
  logic                         skid_valid;
  logic signed [ANGLE_W-1:0]    skid_angle;
  logic                         skid_zero;
  logic                         push, pop;

  assign en = !skid_valid;

  // clamp to the first quadrant, then fold by the dot product sign
  always_comb begin
    if (z[Z_W-1]) begin
      zc = '0;
    end else if (z > Z90) begin
      zc = TH90;
    end else begin
      zc = TH_W'(z);
    end
    if (flags_in.czero) begin
      phi = '0;
    end else if (flags_in.dzero) begin
      phi = TH90;
    end else begin
      phi = zc;
    end
    theta_next = flags_in.dneg ? TH180 - phi : phi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fp <= '0;
    end else if (en) begin
      fp <= flags_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta <= theta_next;
    end
  end

  // round to 1/128 degree and map to the requested range
  assign rsum = {1'b0, theta} + (TH_W+1)'(va_pkg::ROUND_HALF);
  assign r    = rsum[TH_W:8];
  assign rs   = ANGLE_W'(r);

  always_comb begin
    res = '0;
    if (!fp.zero) begin
      unique case (fp.kind)
        va_pkg::REQ_CCW: begin
          res = fp.cneg ? A360 - rs : rs;
          if (res >= A360) res = '0;
        end
        va_pkg::REQ_SIGNED: begin
          res = fp.cneg ? -rs : rs;
          if (res <= A180_NEG) res = A180;
        end
        default: res = '0;
      endcase
    end
  end

  // output word plus one skid word
  assign push = fp.valid;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) skid_valid <= 1'b0;
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        angle       <= skid_angle;
        zero_vector <= skid_zero;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_angle <= res;
        skid_zero  <= fp.zero;
      end else begin
        angle       <= res;
        zero_vector <= fp.zero;
      end
    end
  end

endmodule

// ----- rtl/vector_angle_unit.sv -----
`timescale 1ns / 1ps
// channel   direction  handshake             words
// in        input      in_valid / in_stall   req_type, ref_x, ref_y, vec_x, vec_y
// out       output     out_valid / out_stall angle, zero_vector
//
// one word accepted per cycle while in_stall is low; a word passes through the
// two product stages, two normalize stages, one register per cordic stage,
// the fold stage and the output register
// rst is synchronous and empties the pipeline
// out_stall parks a word in a one-word skid; in_stall rises only while it is full

module vector_angle_unit #(
  parameter int CORDIC_STAGES = va_pkg::CORDIC_STAGES_DEF,
  parameter int COORD_BITS    = va_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              req_type,
  input  logic signed [COORD_BITS-1:0]      ref_x,
  input  logic signed [COORD_BITS-1:0]      ref_y,
  input  logic signed [COORD_BITS-1:0]      vec_x,
  input  logic signed [COORD_BITS-1:0]      vec_y,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [va_pkg::ANGLE_W-1:0] angle,
  output logic                              zero_vector
);

  logic                              en;
  va_pkg::va_flags_t                 f_front, f_norm, f_cordic;
  logic [2*COORD_BITS-1:0]           cmag, dmag;
  logic [va_pkg::NORM_W-1:0]         x_norm, y_norm;
  logic signed [va_pkg::Z_W-1:0]     z;

  assign in_stall = !en;

  va_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .req_type (req_type),
    .ref_x    (ref_x),
    .ref_y    (ref_y),
    .vec_x    (vec_x),
    .vec_y    (vec_y),
    .flags    (f_front),
    .cmag     (cmag),
    .dmag     (dmag)
  );

  va_norm #(.COORD_BITS(COORD_BITS)) u_norm (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .flags_in (f_front),
    .cmag     (cmag),
    .dmag     (dmag),
    .flags    (f_norm),
    .x_norm   (x_norm),
    .y_norm   (y_norm)
  );

  va_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .flags_in (f_norm),
    .x_in     (x_norm),
    .y_in     (y_norm),
    .flags    (f_cordic),
    .z        (z)
  );

  va_post u_post (
    .clk         (clk),
    .rst         (rst),
    .flags_in    (f_cordic),
    .z           (z),
    .out_stall   (out_stall),
    .en          (en),
    .out_valid   (out_valid),
    .angle       (angle),
    .zero_vector (zero_vector)
  );

endmodule

// ----- rtl/va_checker.sv -----
`timescale 1ns / 1ps

module va_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [va_pkg::ANGLE_W-1:0] angle,
  input logic                              zero_vector
);

  localparam logic signed [va_pkg::ANGLE_W-1:0] A360 = va_pkg::ANGLE_W'(va_pkg::OUT_360);
  localparam logic signed [va_pkg::ANGLE_W-1:0] A180_NEG = -va_pkg::ANGLE_W'(va_pkg::OUT_180);

  // input backs up only behind a held output word
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no output word");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word right after reset");

  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_vector) |-> (angle == '0))
    else $error("zero vector with nonzero angle");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((angle > A180_NEG) && (angle < A360)))
    else $error("angle out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(angle) && $stable(zero_vector)))
    else $error("stalled output word changed");

endmodule

bind vector_angle_unit va_checker u_va_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .angle       (angle),
  .zero_vector (zero_vector)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int STAGES     = va_pkg::CORDIC_STAGES_DEF;
  localparam int CBITS      = va_pkg::COORD_BITS_DEF;
  localparam int AW         = va_pkg::ANGLE_W;
  localparam int PIPE_DEPTH = STAGES + 6;
  localparam int NUM_DIR    = 22;
  localparam int NUM_RAND   = 700;
  localparam int HOLD_LEN   = 250;

  typedef struct packed {
    logic signed [AW-1:0] angle;
    logic                 zero;
  } angle_res_t;

  typedef struct packed {
    va_pkg::req_t kind;
    int           rx;
    int           ry;
    int           vx;
    int           vy;
    bit           fixed_exp;
    int           angle;
    bit           zero;
  } va_row_t;

  typedef enum int {
    RX_FLOW,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_t;

  // atan(2^-i) in 2^-15 degree units
  localparam longint MICRO_ROT [va_pkg::TAB_LEN] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57,
    29, 14, 7, 4, 2, 1, 0, 0
  };

  localparam va_row_t DIR_ROWS [NUM_DIR] = '{
    '{va_pkg::REQ_CCW,    0, 0, 0, 0, 1'b1, 0, 1'b1},
    '{va_pkg::REQ_SIGNED, 0, 0, 5, -7, 1'b1, 0, 1'b1},
    '{va_pkg::REQ_CCW,    -32768, -32768, 0, 0, 1'b1, 0, 1'b1},
    '{va_pkg::REQ_CCW,    1, 0, 1, 0, 1'b1, 0, 1'b0},
    '{va_pkg::REQ_SIGNED, 1, 0, -1, 0, 1'b1, 23040, 1'b0},
    '{va_pkg::REQ_CCW,    1, 0, -1, 0, 1'b1, 23040, 1'b0},
    '{va_pkg::REQ_CCW,    1, 0, 0, 1, 1'b1, 11520, 1'b0},
    '{va_pkg::REQ_CCW,    1, 0, 0, -1, 1'b1, 34560, 1'b0},
    '{va_pkg::REQ_SIGNED, 1, 0, 0, -1, 1'b1, -11520, 1'b0},
    '{va_pkg::REQ_SIGNED, 0, 1, 1, 0, 1'b1, -11520, 1'b0},
    '{va_pkg::REQ_CCW,    -32768, -32768, 32767, 32767, 1'b1, 23040, 1'b0},
    '{va_pkg::REQ_SIGNED, 32767, 32767, 32767, 32767, 1'b1, 0, 1'b0},
    '{va_pkg::REQ_CCW,    32767, 0, 32767, -1, 1'b0, 0, 1'b0},
    '{va_pkg::REQ_SIGNED, 1, 0, -32767, -1, 1'b0, 0, 1'b0},
    '{va_pkg::REQ_SIGNED, 1, 0, -32768, 1, 1'b0, 0, 1'b0},
    '{va_pkg::REQ_CCW,    -32768, 32767, 32767, -32768, 1'b0, 0, 1'b0},
    '{va_pkg::REQ_SIGNED, -32768, -32768, -32768, 32767, 1'b0, 0, 1'b0},
    '{va_pkg::REQ_CCW,    1, 1, -1, 1, 1'b1, 11520, 1'b0},
    '{va_pkg::REQ_SIGNED, 3, 4, 4, -3, 1'b0, 0, 1'b0},
    '{va_pkg::REQ_CCW,    -32768, 0, 0, -32768, 1'b1, 11520, 1'b0},
    '{va_pkg::REQ_SIGNED, 32767, -32768, -1, -1, 1'b0, 0, 1'b0},
    '{va_pkg::REQ_CCW,    12345, -23456, -30000, 17, 1'b0, 0, 1'b0}
  };

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic                    req_type;
  logic signed [CBITS-1:0] ref_x;
  logic signed [CBITS-1:0] ref_y;
  logic signed [CBITS-1:0] vec_x;
  logic signed [CBITS-1:0] vec_y;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [AW-1:0]    angle;
  logic                    zero_vector;

  angle_res_t pending_angles[$];
  int         fail_count = 0;
  int         burst_left = 0;
  bit         hold_go = 1'b0;

  vector_angle_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .ref_x       (ref_x),
    .ref_y       (ref_y),
    .vec_x       (vec_x),
    .vec_y       (vec_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .angle       (angle),
    .zero_vector (zero_vector)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic angle_res_t predict_angle(input va_pkg::req_t kind,
                                               input logic signed [CBITS-1:0] ax,
                                               input logic signed [CBITS-1:0] ay,
                                               input logic signed [CBITS-1:0] bx,
                                               input logic signed [CBITS-1:0] by);
    longint cross_v, dot_v, phi, theta, r, res, x, y, z, dx, dy;
    longint unsigned cmag, dmag, ux, uy, big;
    int top;
    angle_res_t o;
    o.angle = '0;
    o.zero  = 1'b0;
    if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
      o.zero = 1'b1;
      return o;
    end
    cross_v = longint'(ax) * longint'(by) - longint'(ay) * longint'(bx);
    dot_v   = longint'(ax) * longint'(bx) + longint'(ay) * longint'(by);
    cmag = (cross_v < 0) ? -cross_v : cross_v;
    dmag = (dot_v < 0) ? -dot_v : dot_v;
    if (cmag == 0) begin
      phi = 0;
    end else if (dmag == 0) begin
      phi = va_pkg::DEG90_UNITS;
    end else begin
      big = (dmag > cmag) ? dmag : cmag;
      top = 63;
      while (top > 0 && !big[top]) top--;
      if (top > va_pkg::NORM_TOP) begin
        ux = dmag >> (top - va_pkg::NORM_TOP);
        uy = cmag >> (top - va_pkg::NORM_TOP);
      end else begin
        ux = dmag << (va_pkg::NORM_TOP - top);
        uy = cmag << (va_pkg::NORM_TOP - top);
      end
      x = longint'(ux);
      y = longint'(uy);
      z = 0;
      for (int i = 0; i < STAGES && i < va_pkg::TAB_LEN; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x = x + dx;
          y = y - dy;
          z = z + MICRO_ROT[i];
        end else begin
          x = x - dx;
          y = y + dy;
          z = z - MICRO_ROT[i];
        end
      end
      if (z < 0) z = 0;
      if (z > va_pkg::DEG90_UNITS) z = va_pkg::DEG90_UNITS;
      phi = z;
    end
    theta = (dot_v < 0) ? va_pkg::DEG180_UNITS - phi : phi;
    r = (theta + va_pkg::ROUND_HALF) >>> 8;
    if (kind == va_pkg::REQ_CCW) begin
      res = (cross_v < 0) ? va_pkg::OUT_360 - r : r;
      if (res >= va_pkg::OUT_360) res = 0;
    end else begin
      res = (cross_v < 0) ? -r : r;
      if (res <= -va_pkg::OUT_180) res = va_pkg::OUT_180;
    end
    o.angle = AW'(res);
    return o;
  endfunction

  function automatic int rand_coord(input int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(0, 5))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic va_row_t random_word();
    va_row_t w;
    int sel, k;
    w = '0;
    w.kind = va_pkg::req_t'($urandom_range(0, 1));
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      w.rx = int'($signed(16'($urandom)));
      w.ry = int'($signed(16'($urandom)));
      w.vx = int'($signed(16'($urandom)));
      w.vy = int'($signed(16'($urandom)));
    end else if (sel < 55) begin
      w.rx = rand_coord(3);
      w.ry = rand_coord(3);
      w.vx = rand_coord(3);
      w.vy = rand_coord(3);
    end else if (sel < 70) begin
      // angle of a lone vector
      w.rx = 1;
      w.ry = 0;
      w.vx = int'($signed(16'($urandom)));
      w.vy = int'($signed(16'($urandom)));
    end else if (sel < 82) begin
      // collinear, same or opposite direction
      w.vx = rand_coord(181);
      w.vy = rand_coord(181);
      k = rand_coord(181);
      w.rx = w.vx * k;
      w.ry = w.vy * k;
    end else if (sel < 92) begin
      // nearly parallel or antiparallel, close to the wrap points
      w.rx = rand_coord(32000);
      w.ry = rand_coord(32000);
      w.vx = w.rx + rand_coord(3);
      w.vy = w.ry + rand_coord(3);
      if ($urandom_range(0, 1) == 1) begin
        w.vx = -w.vx;
        w.vy = -w.vy;
      end
    end else begin
      w.rx = edge_coord();
      w.ry = edge_coord();
      w.vx = edge_coord();
      w.vy = edge_coord();
    end
    return w;
  endfunction

  task automatic send_word(input va_row_t w);
    angle_res_t want;
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    req_type <= w.kind;
    ref_x    <= CBITS'(w.rx);
    ref_y    <= CBITS'(w.ry);
    vec_x    <= CBITS'(w.vx);
    vec_y    <= CBITS'(w.vy);
    do @(posedge clk); while (in_stall);
    if (w.fixed_exp) begin
      want.angle = AW'(w.angle);
      want.zero  = w.zero;
    end else begin
      want = predict_angle(w.kind, CBITS'(w.rx), CBITS'(w.ry), CBITS'(w.vx), CBITS'(w.vy));
    end
    pending_angles.push_back(want);
  endtask

  initial begin : receiver
    int hold_cnt;
    int mode_left;
    int tick;
    rx_mode_t mode;
    hold_cnt  = 0;
    mode_left = 0;
    tick      = 0;
    mode      = RX_FLOW;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_go) begin
        hold_go  = 1'b0;
        hold_cnt = HOLD_LEN;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (mode)
          RX_FLOW:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
          default:  out_stall <= (tick % 5 < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    angle_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_angles.size() == 0) begin
        $error("unexpected word: angle %0d zero_vector %0b", angle, zero_vector);
        fail_count++;
      end else begin
        want = pending_angles.pop_front();
        if (angle !== want.angle) begin
          $error("angle: expected %0d, got %0d", want.angle, angle);
          fail_count++;
        end
        if (zero_vector !== want.zero) begin
          $error("zero_vector: expected %0b, got %0b", want.zero, zero_vector);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2000000;
    $display("** vector_angle_unit: FAILED **");
    $finish;
  end

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    req_type = 1'b0;
    ref_x    = '0;
    ref_y    = '0;
    vec_x    = '0;
    vec_y    = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIR; i++) send_word(DIR_ROWS[i]);

    for (int n = 0; n < NUM_RAND; n++) begin
      // long receiver hold-off so the pipe fills and backs up
      if (n == 300) hold_go = 1'b1;
      send_word(random_word());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_angles.size() == 0);
    repeat (PIPE_DEPTH + 8) @(posedge clk);
    if (fail_count == 0 && pending_angles.size() == 0) begin
      $display("** vector_angle_unit: PASSED **");
    end else begin
      $display("** vector_angle_unit: FAILED **");
    end
    $finish;
  end

endmodule
